// ===== design/tts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg
// Types, constants and codes shared by the tridiagonal solver modules.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int WORD_W   = 48;
    localparam int FRAC_W   = 24;
    localparam int IDX_W    = 11;
    localparam int STAT_W   = 2;
    localparam int MAX_ROWS_DEF = 1024;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
    localparam logic [STAT_W-1:0] ST_SAT = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD = 2'd2;

    typedef struct packed {
        logic                     action;
        logic signed [WORD_W-1:0] coef_sub;
        logic signed [WORD_W-1:0] coef_super;
        logic signed [WORD_W-1:0] coef_diag;
        logic signed [WORD_W-1:0] rhs;
        logic                     last_row;
        logic [IDX_W-1:0]         read_index;
    } t_in_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] y_value;
        logic [IDX_W-1:0]         y_index;
        logic [STAT_W-1:0]        status;
    } t_out_rsp;

    typedef enum logic {
        UOP_MUL,
        UOP_DIV
    } t_uop;

    typedef enum logic [1:0] {
        U_IDLE,
        U_PREP,
        U_RUN,
        U_DONE
    } t_ustate;

    typedef struct packed {
        logic                     start;
        t_uop                     op;
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] y;
    } t_unit_cmd;

    typedef struct packed {
        logic                     done;
        logic                     err;
        logic signed [WORD_W-1:0] value;
    } t_unit_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_INIT,
        S_LD_MUL1,
        S_LD_SUB,
        S_LD_DIV1,
        S_LD_MUL2,
        S_LD_ADD,
        S_LD_DIV2,
        S_BS_INIT,
        S_BS_RD,
        S_BS_MULST,
        S_BS_MUL,
        S_BS_ADD,
        S_RD_MEM,
        S_RD_OUT
    } t_state;

endpackage

// ===== design/tts_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_unit
// Shared shift-add multiplier and restoring divider, one bit per cycle,
// fixed point with saturation to the word range.
// ----------------------------------------------------------------------------
module tts_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tts_pkg::t_unit_cmd  i_cmd,
    output tts_pkg::t_unit_rsp  o_rsp
);

    localparam int W     = tts_pkg::WORD_W;
    localparam int F     = tts_pkg::FRAC_W;
    localparam int QW    = W + F;
    localparam int CNT_W = $clog2(QW + 1);
    localparam logic [2*W-1:0] LIM = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};

    tts_pkg::t_ustate r_state, n_state;
    tts_pkg::t_uop    r_op;
    logic signed [W-1:0] r_x, r_y;
    logic [W-1:0]     r_p;
    logic [W-1:0]     r_hi;
    logic [QW-1:0]    r_lo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg, r_xneg, r_dz;

    logic [W-1:0]     mx, my;
    logic [W:0]       rs;
    logic [W+1:0]     opa, opb, sum;
    logic             is_div, ge;
    logic [2*W-1:0]   mres;
    logic             sat;

    assign mx     = r_x[W-1] ? (~r_x + 1'b1) : r_x;
    assign my     = r_y[W-1] ? (~r_y + 1'b1) : r_y;
    assign is_div = (r_op == tts_pkg::UOP_DIV);

    // one adder serves both: add multiplicand, or trial-subtract divisor
    assign rs  = {r_hi, r_lo[QW-1]};
    assign opa = is_div ? {1'b0, rs} : {2'b00, r_hi};
    assign opb = is_div ? ~{2'b00, r_p} : (r_lo[0] ? {2'b00, r_p} : '0);
    assign sum = opa + opb + {{(W+1){1'b0}}, is_div};
    assign ge  = ~sum[W+1];

    always_comb begin
        mres = is_div ? {{(W-F){1'b0}}, r_lo} : {{F{1'b0}}, r_hi, r_lo[W-1:F]};
        sat  = r_neg ? (mres > LIM) : (mres >= LIM);
        o_rsp.done = (r_state == tts_pkg::U_DONE);
        if (r_dz) begin
            o_rsp.err   = 1'b1;
            o_rsp.value = r_xneg ? tts_pkg::WORD_MIN : tts_pkg::WORD_MAX;
        end else if (sat) begin
            o_rsp.err   = 1'b1;
            o_rsp.value = r_neg ? tts_pkg::WORD_MIN : tts_pkg::WORD_MAX;
        end else begin
            o_rsp.err   = 1'b0;
            o_rsp.value = r_neg ? (~mres[W-1:0] + 1'b1) : mres[W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tts_pkg::U_IDLE: begin
                if (i_cmd.start) n_state = tts_pkg::U_PREP;
            end
            tts_pkg::U_PREP: begin
                n_state = (is_div && my == '0) ? tts_pkg::U_DONE : tts_pkg::U_RUN;
            end
            tts_pkg::U_RUN: begin
                if (r_cnt == CNT_W'(1)) n_state = tts_pkg::U_DONE;
            end
            tts_pkg::U_DONE: begin
                n_state = i_cmd.start ? tts_pkg::U_PREP : tts_pkg::U_IDLE;
            end
            default: n_state = tts_pkg::U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tts_pkg::U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op <= i_cmd.op;
            r_x  <= i_cmd.x;
            r_y  <= i_cmd.y;
        end
        if (r_state == tts_pkg::U_PREP) begin
            r_p    <= is_div ? my : mx;
            r_neg  <= r_x[W-1] ^ r_y[W-1];
            r_xneg <= r_x[W-1];
            r_dz   <= is_div && (my == '0);
            r_hi   <= '0;
            r_lo   <= is_div ? {mx, {F{1'b0}}} : {{F{1'b0}}, my};
            r_cnt  <= is_div ? CNT_W'(QW) : CNT_W'(W);
        end else if (r_state == tts_pkg::U_RUN) begin
            r_cnt <= r_cnt - 1'b1;
            if (is_div) begin
                r_hi <= ge ? sum[W-1:0] : rs[W-1:0];
                r_lo <= {r_lo[QW-2:0], ge};
            end else begin
                r_hi <= sum[W:1];
                r_lo <= {r_lo[QW-1:W], sum[0], r_lo[W-1:1]};
            end
        end
    end

endmodule

// ===== design/tts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer for forward sweep, back-substitution and reads; holds the
// alpha, beta and solution stores.
// ----------------------------------------------------------------------------
module tts_ctrl #(
    parameter int MAX_ROWS = tts_pkg::MAX_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  tts_pkg::t_in_req                  i_in_req,
    input  logic signed [tts_pkg::WORD_W-1:0] i_gamma_left,
    input  logic signed [tts_pkg::WORD_W-1:0] i_gamma_right,
    input  logic                              i_out_busy,
    output logic                              o_rsp_valid,
    output tts_pkg::t_out_rsp                 o_rsp,
    output tts_pkg::t_unit_cmd                o_ucmd,
    input  tts_pkg::t_unit_rsp                i_ursp
);

    localparam int W      = tts_pkg::WORD_W;
    localparam int AW_AB  = $clog2(MAX_ROWS + 1);
    localparam int AW_SOL = $clog2(MAX_ROWS + 2);
    localparam int CW     = ((tts_pkg::IDX_W > AW_SOL) ? tts_pkg::IDX_W : AW_SOL) + 1;

    typedef struct packed {
        logic         err;
        logic [W-1:0] value;
    } t_sat;

    function automatic t_sat sat_add(input logic [W-1:0] x, input logic [W-1:0] y);
        logic [W:0] s;
        t_sat       r;
        s       = {x[W-1], x} + {y[W-1], y};
        r.err   = s[W] ^ s[W-1];
        r.value = r.err ? (s[W] ? tts_pkg::WORD_MIN : tts_pkg::WORD_MAX) : s[W-1:0];
        return r;
    endfunction

    function automatic t_sat sat_sub(input logic [W-1:0] x, input logic [W-1:0] y);
        logic [W:0] s;
        t_sat       r;
        s       = {x[W-1], x} - {y[W-1], y};
        r.err   = s[W] ^ s[W-1];
        r.value = r.err ? (s[W] ? tts_pkg::WORD_MIN : tts_pkg::WORD_MAX) : s[W-1:0];
        return r;
    endfunction

    tts_pkg::t_state r_state, n_state;
    logic [AW_AB-1:0]  r_rc;
    logic              r_err, r_solved;
    logic [AW_SOL-1:0] r_bi;

    logic signed [W-1:0] r_a, r_b, r_c, r_f;
    logic                r_last;
    logic [tts_pkg::IDX_W-1:0] r_idx;
    logic signed [W-1:0] r_t, r_d, r_alpha_new, r_alpha_prev, r_beta_prev, r_y;

    logic signed [W-1:0] alpha_mem [0:MAX_ROWS];
    logic signed [W-1:0] beta_mem  [0:MAX_ROWS];
    logic signed [W-1:0] sol_mem   [0:MAX_ROWS+1];
    logic signed [W-1:0] r_alpha_q, r_beta_q, r_sol_q;

    logic              ab_we, sol_we;
    logic [AW_AB-1:0]  ab_waddr, ab_raddr;
    logic [AW_SOL-1:0] sol_waddr, sol_raddr, bim1;
    logic signed [W-1:0] alpha_wd, beta_wd, sol_wd;
    logic [AW_AB-1:0]  rc_inc;
    logic [CW-1:0]     idx_ext, lim_ext;
    logic              bad;
    t_sat              d_sat, num_sat, y_sat;
    logic              accept;

    assign rc_inc    = r_rc + 1'b1;
    assign bim1      = r_bi - 1'b1;
    assign ab_raddr  = bim1[AW_AB-1:0];
    assign idx_ext   = CW'(r_idx);
    assign lim_ext   = CW'(r_rc) + CW'(1);
    assign sol_raddr = idx_ext[AW_SOL-1:0];
    assign d_sat     = sat_sub(r_c, r_t);
    assign num_sat   = sat_add(r_t, r_f);
    assign y_sat     = sat_add(r_t, r_beta_q);
    assign o_in_ready = (r_state == tts_pkg::S_IDLE);
    assign accept    = i_in_valid && o_in_ready;
    assign bad       = !r_solved || (idx_ext > lim_ext);

    always_comb begin
        n_state     = r_state;
        o_ucmd      = '0;
        ab_we       = 1'b0;
        ab_waddr    = rc_inc;
        alpha_wd    = r_alpha_new;
        beta_wd     = i_ursp.value;
        sol_we      = 1'b0;
        sol_waddr   = bim1;
        sol_wd      = y_sat.value;
        o_rsp_valid = 1'b0;
        o_rsp.y_index = r_idx;
        o_rsp.y_value = bad ? '0 : r_sol_q;
        o_rsp.status  = bad ? tts_pkg::ST_BAD : (r_err ? tts_pkg::ST_SAT : tts_pkg::ST_OK);
        unique case (r_state)
            tts_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_req.action == tts_pkg::ACT_LOAD) ?
                              tts_pkg::S_LD_INIT : tts_pkg::S_RD_MEM;
                end
            end
            tts_pkg::S_LD_INIT: begin
                if (r_rc == '0) begin
                    ab_we    = 1'b1;
                    ab_waddr = '0;
                    alpha_wd = '0;
                    beta_wd  = i_gamma_left;
                end
                o_ucmd.start = 1'b1;
                o_ucmd.op    = tts_pkg::UOP_MUL;
                o_ucmd.x     = r_a;
                o_ucmd.y     = (r_rc == '0) ? '0 : r_alpha_prev;
                n_state      = tts_pkg::S_LD_MUL1;
            end
            tts_pkg::S_LD_MUL1: begin
                if (i_ursp.done) n_state = tts_pkg::S_LD_SUB;
            end
            tts_pkg::S_LD_SUB: begin
                o_ucmd.start = 1'b1;
                o_ucmd.op    = tts_pkg::UOP_DIV;
                o_ucmd.x     = r_b;
                o_ucmd.y     = d_sat.value;
                n_state      = tts_pkg::S_LD_DIV1;
            end
            tts_pkg::S_LD_DIV1: begin
                if (i_ursp.done) begin
                    o_ucmd.start = 1'b1;
                    o_ucmd.op    = tts_pkg::UOP_MUL;
                    o_ucmd.x     = r_a;
                    o_ucmd.y     = r_beta_prev;
                    n_state      = tts_pkg::S_LD_MUL2;
                end
            end
            tts_pkg::S_LD_MUL2: begin
                if (i_ursp.done) n_state = tts_pkg::S_LD_ADD;
            end
            tts_pkg::S_LD_ADD: begin
                o_ucmd.start = 1'b1;
                o_ucmd.op    = tts_pkg::UOP_DIV;
                o_ucmd.x     = num_sat.value;
                o_ucmd.y     = r_d;
                n_state      = tts_pkg::S_LD_DIV2;
            end
            tts_pkg::S_LD_DIV2: begin
                if (i_ursp.done) begin
                    ab_we   = 1'b1;
                    n_state = (r_last || rc_inc == AW_AB'(MAX_ROWS)) ?
                              tts_pkg::S_BS_INIT : tts_pkg::S_IDLE;
                end
            end
            tts_pkg::S_BS_INIT: begin
                sol_we    = 1'b1;
                sol_waddr = AW_SOL'(r_rc) + 1'b1;
                sol_wd    = i_gamma_right;
                n_state   = tts_pkg::S_BS_RD;
            end
            tts_pkg::S_BS_RD: begin
                n_state = tts_pkg::S_BS_MULST;
            end
            tts_pkg::S_BS_MULST: begin
                o_ucmd.start = 1'b1;
                o_ucmd.op    = tts_pkg::UOP_MUL;
                o_ucmd.x     = r_alpha_q;
                o_ucmd.y     = r_y;
                n_state      = tts_pkg::S_BS_MUL;
            end
            tts_pkg::S_BS_MUL: begin
                if (i_ursp.done) n_state = tts_pkg::S_BS_ADD;
            end
            tts_pkg::S_BS_ADD: begin
                sol_we  = 1'b1;
                n_state = (r_bi == AW_SOL'(1)) ? tts_pkg::S_IDLE : tts_pkg::S_BS_RD;
            end
            tts_pkg::S_RD_MEM: begin
                n_state = tts_pkg::S_RD_OUT;
            end
            tts_pkg::S_RD_OUT: begin
                if (!i_out_busy) begin
                    o_rsp_valid = 1'b1;
                    n_state     = tts_pkg::S_IDLE;
                end
            end
            default: n_state = tts_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tts_pkg::S_IDLE;
            r_rc     <= '0;
            r_err    <= 1'b0;
            r_solved <= 1'b0;
            r_bi     <= '0;
        end else begin
            r_state <= n_state;
            // a load after a finished solve starts a new system
            if (accept && i_in_req.action == tts_pkg::ACT_LOAD && r_solved) begin
                r_solved <= 1'b0;
                r_err    <= 1'b0;
                r_rc     <= '0;
            end
            if (i_ursp.done && i_ursp.err) r_err <= 1'b1;
            if (r_state == tts_pkg::S_LD_SUB && d_sat.err) r_err <= 1'b1;
            if (r_state == tts_pkg::S_LD_ADD && num_sat.err) r_err <= 1'b1;
            if (r_state == tts_pkg::S_LD_DIV2 && i_ursp.done) r_rc <= rc_inc;
            if (r_state == tts_pkg::S_BS_INIT) r_bi <= AW_SOL'(r_rc) + 1'b1;
            if (r_state == tts_pkg::S_BS_ADD) begin
                r_bi <= bim1;
                if (y_sat.err) r_err <= 1'b1;
                if (r_bi == AW_SOL'(1)) r_solved <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a    <= i_in_req.coef_sub;
            r_b    <= i_in_req.coef_super;
            r_c    <= i_in_req.coef_diag;
            r_f    <= i_in_req.rhs;
            r_last <= i_in_req.last_row;
            r_idx  <= i_in_req.read_index;
        end
        if (r_state == tts_pkg::S_LD_INIT && r_rc == '0) begin
            r_alpha_prev <= '0;
            r_beta_prev  <= i_gamma_left;
        end
        if (i_ursp.done && (r_state == tts_pkg::S_LD_MUL1 ||
                            r_state == tts_pkg::S_LD_MUL2 ||
                            r_state == tts_pkg::S_BS_MUL)) begin
            r_t <= i_ursp.value;
        end
        if (r_state == tts_pkg::S_LD_SUB) r_d <= d_sat.value;
        if (r_state == tts_pkg::S_LD_DIV1 && i_ursp.done) r_alpha_new <= i_ursp.value;
        if (r_state == tts_pkg::S_LD_DIV2 && i_ursp.done) begin
            r_alpha_prev <= r_alpha_new;
            r_beta_prev  <= i_ursp.value;
        end
        if (r_state == tts_pkg::S_BS_INIT) r_y <= i_gamma_right;
        if (r_state == tts_pkg::S_BS_ADD) r_y <= y_sat.value;
    end

    always_ff @(posedge i_clk) begin
        if (ab_we) begin
            alpha_mem[ab_waddr] <= alpha_wd;
            beta_mem[ab_waddr]  <= beta_wd;
        end
        r_alpha_q <= alpha_mem[ab_raddr];
        r_beta_q  <= beta_mem[ab_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sol_we) sol_mem[sol_waddr] <= sol_wd;
        r_sol_q <= sol_mem[sol_raddr];
    end

`ifndef SYNTHESIS
    a_rows_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rc <= AW_AB'(MAX_ROWS))
        else $error("row count beyond store depth");

    a_rsp_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !i_out_busy)
        else $error("result issued while output register full");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ursp.done |=> !i_ursp.done)
        else $error("arithmetic unit done held longer than one cycle");

    a_solved_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_solved) && $past(i_rst_n)) |->
        $past(accept && i_in_req.action == tts_pkg::ACT_LOAD))
        else $error("solved flag dropped without a new row");
`endif

endmodule

// ===== design/tridiagonal_thomas_solver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tridiagonal_thomas_solver_core
// Tridiagonal system solver: forward sweep per loaded row, back-substitution
// after the last row or when the store fills, indexed reads of the solution.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        input      i_in_valid/o_in_stall i_in_req  (tts_pkg::t_in_req)
//  out       output     o_out_valid/i_out_stall o_out_rsp (tts_pkg::t_out_rsp)
//  cfg       input      i_cfg_we              i_cfg_index, i_cfg_wdata
//
// A row request is finished before the next request is accepted: two multiplies
// and two divides on the one shared unit, plus sequencing states; a zero divisor
// cuts that divide short. The last row adds back-substitution, one multiply per
// solution entry. A read request passes through a store read and an output state;
// its result waits in the output register.
// Reset clears the sequencer, row count and status flags; stores need no clear.
// ----------------------------------------------------------------------------
module tridiagonal_thomas_solver_core #(
    parameter int MAX_ROWS = tts_pkg::MAX_ROWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  tts_pkg::t_in_req           i_in_req,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output tts_pkg::t_out_rsp          o_out_rsp,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [tts_pkg::WORD_W-1:0] i_cfg_wdata
);

    localparam logic REG_GAMMA_LEFT  = 1'b0;
    localparam logic REG_GAMMA_RIGHT = 1'b1;

    logic signed [tts_pkg::WORD_W-1:0] r_gamma_left, r_gamma_right;
    logic               r_out_valid;
    tts_pkg::t_out_rsp  r_out;
    logic               in_ready, rsp_valid;
    tts_pkg::t_out_rsp  rsp;
    tts_pkg::t_unit_cmd ucmd;
    tts_pkg::t_unit_rsp ursp;

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma_left  <= '0;
            r_gamma_right <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GAMMA_LEFT:  r_gamma_left  <= i_cfg_wdata;
                REG_GAMMA_RIGHT: r_gamma_right <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_valid) r_out <= rsp;
    end

    tts_ctrl #(
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (in_ready),
        .i_in_req      (i_in_req),
        .i_gamma_left  (r_gamma_left),
        .i_gamma_right (r_gamma_right),
        .i_out_busy    (r_out_valid),
        .o_rsp_valid   (rsp_valid),
        .o_rsp         (rsp),
        .o_ucmd        (ucmd),
        .i_ursp        (ursp)
    );

    tts_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ucmd),
        .o_rsp   (ursp)
    );

endmodule

// ===== bench/tb_tridiagonal_thomas_solver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tridiagonal_thomas_solver_core
// Self-checking bench for the tridiagonal solver core. Row and read requests
// go in with random gaps. Each accepted request runs through a fixed-point
// model of the forward sweep and back-substitution. Every returned solution
// value is checked field by field against the model, while the output side
// stalls at random. Covered: boundary registers, saturation and division by
// zero, reads before a solve and out of range, the full-store forced solve,
// and random well-formed systems mixed with noise.
// ----------------------------------------------------------------------------
module tb_tridiagonal_thomas_solver_core;

    localparam int     N_ROWS    = 1024;
    localparam int     ITEM_GOAL = 1150;
    localparam longint CYC_LIMIT = 3000000;
    localparam longint VMAX      = 64'sd140737488355327;
    localparam longint VMIN      = -64'sd140737488355328;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    tts_pkg::t_in_req  in_req = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    tts_pkg::t_out_rsp o_out_rsp;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [tts_pkg::WORD_W-1:0] cfg_wdata = '0;

    tridiagonal_thomas_solver_core #(.MAX_ROWS(N_ROWS)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_rsp  (o_out_rsp),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // solver model state
    longint   alpha_m [0:N_ROWS];
    longint   beta_m  [0:N_ROWS];
    longint   y_m     [0:N_ROWS+1];
    int       rows_m = 0;
    bit       err_m = 0;
    bit       solved_m = 0;
    longint   left_m = 0;
    longint   right_m = 0;

    tts_pkg::t_out_rsp pending_y[$];
    int       mismatches = 0;
    int       items_sent = 0;
    longint   cycles = 0;

    function automatic logic [127:0] magn(longint v);
        return v < 0 ? 128'(-v) : 128'(v);
    endfunction

    function automatic longint clamp_mag(bit neg, logic [127:0] m);
        if (neg) begin
            if (m > 128'h8000_0000_0000) begin
                err_m = 1;
                return VMIN;
            end
            return -longint'(m[63:0]);
        end
        if (m > 128'h7FFF_FFFF_FFFF) begin
            err_m = 1;
            return VMAX;
        end
        return longint'(m[63:0]);
    endfunction

    function automatic longint clamp_sum(longint s);
        if (s > VMAX) begin
            err_m = 1;
            return VMAX;
        end
        if (s < VMIN) begin
            err_m = 1;
            return VMIN;
        end
        return s;
    endfunction

    function automatic longint fx_product(longint x, longint y);
        logic [127:0] m;
        m = (magn(x) * magn(y)) >> tts_pkg::FRAC_W;
        return clamp_mag((x < 0) != (y < 0), m);
    endfunction

    function automatic longint fx_quotient(longint n, longint d);
        logic [127:0] m;
        if (d == 0) begin
            err_m = 1;
            return n < 0 ? VMIN : VMAX;
        end
        m = (magn(n) << tts_pkg::FRAC_W) / magn(d);
        return clamp_mag((n < 0) != (d < 0), m);
    endfunction

    task automatic solve_back();
        y_m[rows_m+1] = right_m;
        for (int i = rows_m + 1; i > 0; i--)
            y_m[i-1] = clamp_sum(fx_product(alpha_m[i-1], y_m[i]) + beta_m[i-1]);
        solved_m = 1;
    endtask

    task automatic predict_solution(input tts_pkg::t_in_req r);
        longint   a, b, c, f, d;
        tts_pkg::t_out_rsp e;
        a = longint'(r.coef_sub);
        b = longint'(r.coef_super);
        c = longint'(r.coef_diag);
        f = longint'(r.rhs);
        if (r.action == tts_pkg::ACT_LOAD) begin
            if (solved_m) begin
                solved_m = 0;
                err_m = 0;
                rows_m = 0;
            end
            if (rows_m == 0) begin
                alpha_m[0] = 0;
                beta_m[0] = left_m;
            end
            d = clamp_sum(c - fx_product(a, alpha_m[rows_m]));
            alpha_m[rows_m+1] = fx_quotient(b, d);
            beta_m[rows_m+1] = fx_quotient(clamp_sum(fx_product(a, beta_m[rows_m]) + f), d);
            rows_m++;
            if (r.last_row || rows_m >= N_ROWS)
                solve_back();
        end else begin
            e.y_index = r.read_index;
            if (!solved_m || r.read_index > rows_m + 1) begin
                e.y_value = '0;
                e.status = tts_pkg::ST_BAD;
            end else begin
                e.y_value = y_m[r.read_index][tts_pkg::WORD_W-1:0];
                e.status = err_m ? tts_pkg::ST_SAT : tts_pkg::ST_OK;
            end
            pending_y = {pending_y, e};
        end
    endtask

    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_req(input tts_pkg::t_in_req r);
        int g;
        g = idle_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req <= r;
        do @(posedge i_clk); while (o_in_stall);
        predict_solution(r);
        items_sent++;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // output side: random stall streaks, with calm stretches between them
    initial begin
        forever begin
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if (idle_len() > 0) begin
                out_stall <= 1'b1;
                repeat (idle_len() + 1) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        tts_pkg::t_out_rsp e;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_y.size() == 0) begin
                report_mismatch("unexpected result, index", o_out_rsp.y_index, -1);
            end else begin
                e = pending_y.pop_front();
                if (o_out_rsp.y_value !== e.y_value)
                    report_mismatch("y_value", o_out_rsp.y_value, e.y_value);
                if (o_out_rsp.y_index !== e.y_index)
                    report_mismatch("y_index", o_out_rsp.y_index, e.y_index);
                if (o_out_rsp.status !== e.status)
                    report_mismatch("status", o_out_rsp.status, e.status);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input longint v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v[tts_pkg::WORD_W-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == 1'b0) left_m = longint'($signed(v[tts_pkg::WORD_W-1:0]));
        else right_m = longint'($signed(v[tts_pkg::WORD_W-1:0]));
    endtask

    function automatic longint rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return longint'($signed(w[tts_pkg::WORD_W-1:0]));
    endfunction

    function automatic tts_pkg::t_in_req make_row(longint a, longint b, longint c, longint f,
                                                  logic last);
        tts_pkg::t_in_req r;
        r.action = tts_pkg::ACT_LOAD;
        r.coef_sub = a[tts_pkg::WORD_W-1:0];
        r.coef_super = b[tts_pkg::WORD_W-1:0];
        r.coef_diag = c[tts_pkg::WORD_W-1:0];
        r.rhs = f[tts_pkg::WORD_W-1:0];
        r.last_row = last;
        r.read_index = tts_pkg::IDX_W'($urandom);
        return r;
    endfunction

    // diagonally dominant row: keeps the sweep well inside the word range
    function automatic tts_pkg::t_in_req sane_row(logic last);
        longint c;
        c = (longint'($urandom_range(4, 8)) << tts_pkg::FRAC_W)
            + $urandom_range(0, (1 << tts_pkg::FRAC_W) - 1);
        if ($urandom_range(0, 1)) c = -c;
        return make_row(longint'($signed($urandom)) >>> 7, longint'($signed($urandom)) >>> 7,
                        c, longint'($signed($urandom)), last);
    endfunction

    task automatic read_y(input int idx);
        tts_pkg::t_in_req r;
        r = make_row(rand_word(), rand_word(), rand_word(), rand_word(), $urandom_range(0, 1));
        r.action = tts_pkg::ACT_READ;
        r.read_index = idx[tts_pkg::IDX_W-1:0];
        send_req(r);
    endtask

    // drain: a read returns only after all earlier work, then idle a little
    task automatic settle();
        read_y(0);
        in_valid <= 1'b0;
        while (pending_y.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic test_unsolved_reads();
        read_y(0);
        read_y(2047);
        read_y(1025);
        settle();
    endtask

    task automatic test_saturation();
        write_reg(1'b0, VMAX);
        write_reg(1'b1, VMIN);
        // zero diagonal on the first row: divide by zero with both signs
        send_req(make_row(VMIN, VMAX, 0, VMAX, 1'b0));
        send_req(make_row(VMAX, VMIN, 0, VMIN, 1'b0));
        send_req(make_row(VMIN, VMIN, VMAX, 0, 1'b0));
        read_y(1);
        send_req(make_row(VMAX, VMAX, VMIN, VMAX, 1'b1));
        for (int i = 0; i <= 6; i++) read_y(i);
        read_y(2047);
        settle();
        write_reg(1'b0, 0);
        write_reg(1'b1, 0);
        send_req(sane_row(1'b1));
        read_y(0);
        read_y(1);
        read_y(2);
        read_y(3);
        settle();
    endtask

    task automatic test_full_store();
        write_reg(1'b0, rand_word() >>> 20);
        write_reg(1'b1, rand_word() >>> 20);
        for (int i = 0; i < N_ROWS; i++) send_req(sane_row(1'b0));
        read_y(0);
        read_y(N_ROWS);
        read_y(N_ROWS + 1);
        read_y(N_ROWS + 2);
        repeat (4) read_y($urandom_range(0, N_ROWS + 1));
        settle();
    endtask

    task automatic test_random_systems();
        int n;
        while (items_sent < ITEM_GOAL) begin
            if ($urandom_range(0, 5) == 0) begin
                settle();
                write_reg(1'b0, $urandom_range(0, 7) == 0 ? VMAX : rand_word() >>> 18);
                write_reg(1'b1, $urandom_range(0, 7) == 0 ? VMIN : rand_word() >>> 18);
            end
            n = $urandom_range(0, 9) == 0 ? $urandom_range(8, 40) : $urandom_range(1, 6);
            for (int i = 1; i <= n; i++) begin
                if ($urandom_range(0, 15) == 0) read_y($urandom_range(0, 7));
                if ($urandom_range(0, 9) == 0)
                    send_req(make_row(rand_word(), rand_word(), rand_word(), rand_word(),
                                      i == n));
                else
                    send_req(sane_row(i == n));
            end
            repeat ($urandom_range(2, 5)) begin
                case ($urandom_range(0, 5))
                    0:       read_y($urandom);
                    1:       read_y(n + $urandom_range(1, 3));
                    default: read_y($urandom_range(0, n + 1));
                endcase
            end
        end
        settle();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_unsolved_reads();
        test_saturation();
        test_full_store();
        test_random_systems();
        in_valid <= 1'b0;
        while (pending_y.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
design/tts_pkg.sv
design/tts_unit.sv
design/tts_ctrl.sv
design/tridiagonal_thomas_solver_core.sv
bench/tb_tridiagonal_thomas_solver_core.sv
